// ----- rtl/core/uhj_pkg.sv -----
// Shared types, constants and coefficient tables for the two-channel UHJ encoder.
package uhj_pkg;

   localparam int CoefBits   = 18;
   localparam int HistBits   = 32;
   localparam int OperBits   = 33;
   localparam int ProdBits   = 51;
   localparam int AccBits    = 53;
   localparam int FracShift  = 17;
   localparam int DiffBits   = AccBits - FracShift + 1;
   localparam int SumBits    = 34;
   localparam int DeltaBits  = 36;
   localparam int SecCount   = 12;
   localparam int SecBits    = 4;
   localparam int OpBits     = 5;
   localparam int FirstSecOp = 5;
   localparam int LastOp     = FirstSecOp + SecCount - 1;
   localparam int YLastSec   = 3;
   localparam int WxLastSec  = 7;
   localparam int SLastSec   = 11;

   localparam logic signed [AccBits-1:0]  RoundHalf = AccBits'(64'd1 << (FracShift - 1));
   localparam logic signed [DiffBits-1:0] HistMax   = DiffBits'(64'd2147483647);
   localparam logic signed [DiffBits-1:0] HistMin   = -HistMax - DiffBits'(1);

   typedef logic signed [CoefBits-1:0] coef_type;
   typedef logic signed [HistBits-1:0] hist_type;

   typedef enum logic [2:0] {
      MS_Y,
      MS_WX_W,
      MS_WX_X,
      MS_S_W,
      MS_S_X,
      MS_SEC
   } mul_sel_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_WR,
      ST_FIN_SUM,
      ST_FIN_DELTA,
      ST_FIN_OUT
   } state_type;

   typedef struct packed {
      logic               load;
      logic               mul_en;
      mul_sel_type        mul_sel;
      logic               acc_en;
      logic               acc_first;
      logic               acc_round;
      logic               term_wr;
      logic [1:0]         term_idx;
      logic               sec_wr;
      logic [SecBits-1:0] sec_idx;
      logic               fin_sum;
      logic               fin_delta;
      logic               fin_out;
   } cmd_type;

   // Input matrix gains, Q1.17
   function automatic coef_type pre_coef(mul_sel_type sel);
      coef_type c;
      unique case (sel)
         MS_Y:    c = 18'sd85911;
         MS_WX_W: c = -18'sd44829;
         MS_WX_X: c = 18'sd66828;
         MS_S_W:  c = 18'sd123167;
         MS_S_X:  c = 18'sd24324;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Allpass coefficients; the WX chain uses set two, Y and S use set one
   function automatic coef_type sec_coef(logic [SecBits-1:0] idx);
      coef_type c;
      if (idx[3:2] == 2'd1) begin
         unique case (idx[1:0])
            2'd0: c = 18'sd21202;
            2'd1: c = 18'sd96080;
            2'd2: c = 18'sd123909;
            default: c = 18'sd129840;
         endcase
      end else begin
         unique case (idx[1:0])
            2'd0: c = 18'sd62836;
            2'd1: c = 18'sd114848;
            2'd2: c = 18'sd128005;
            default: c = 18'sd130744;
         endcase
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/uhj_datapath.sv -----
// Datapath: shared multiplier, accumulator, allpass histories and output mixing.
module uhj_datapath #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  uhj_pkg::cmd_type              cmd,
   input  logic signed [SAMPLE_BITS-1:0] w_sample,
   input  logic signed [SAMPLE_BITS-1:0] x_sample,
   input  logic signed [SAMPLE_BITS-1:0] y_sample,
   input  logic signed [SAMPLE_BITS-1:0] left_accum,
   input  logic signed [SAMPLE_BITS-1:0] right_accum,
   input  logic                          last_in_block,
   output logic signed [SAMPLE_BITS-1:0] left_out,
   output logic signed [SAMPLE_BITS-1:0] right_out,
   output logic                          end_of_block
);

   localparam int QShl = (SAMPLE_BITS <= 30) ? 30 - SAMPLE_BITS : 0;
   localparam int QShr = (SAMPLE_BITS > 30) ? SAMPLE_BITS - 30 : 0;
   localparam int DShr = (SAMPLE_BITS <= 31) ? 31 - SAMPLE_BITS : 0;
   localparam logic signed [63:0] DHalf = (DShr == 0) ? 64'sd0 : (64'sd1 <<< (DShr - 1));
   localparam logic signed [63:0] SampleMax = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] SampleMin = -SampleMax - 64'sd1;
   localparam logic [uhj_pkg::SecBits-1:0] SecIdxWx = uhj_pkg::SecBits'(uhj_pkg::WxLastSec);

   function automatic uhj_pkg::hist_type to_q29(logic signed [SAMPLE_BITS-1:0] s);
      logic signed [63:0] t;
      t = 64'(s);
      t = t <<< QShl;
      t = t >>> QShr;
      return t[uhj_pkg::HistBits-1:0];
   endfunction

   function automatic logic signed [uhj_pkg::DeltaBits-1:0] to_delta(
      logic signed [uhj_pkg::SumBits-1:0] v);
      logic signed [63:0] t;
      t = 64'(v);
      if (SAMPLE_BITS <= 31) begin
         t = (t + DHalf) >>> DShr;
      end else begin
         t = t <<< 1;
      end
      return t[uhj_pkg::DeltaBits-1:0];
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] mix_sat(
      logic signed [SAMPLE_BITS-1:0] acc, logic signed [uhj_pkg::DeltaBits-1:0] d);
      logic signed [63:0] t;
      t = 64'(acc) + 64'(d);
      if (t > SampleMax) begin
         t = SampleMax;
      end else if (t < SampleMin) begin
         t = SampleMin;
      end
      return t[SAMPLE_BITS-1:0];
   endfunction

   uhj_pkg::hist_type w_q_ff, x_q_ff, y_q_ff;
   logic signed [SAMPLE_BITS-1:0] la_ff, ra_ff;
   logic last_ff;
   uhj_pkg::hist_type term0_ff, term1_ff, term2_ff;
   uhj_pkg::hist_type v_ff, wx_ff, ydel_ff, sdel_ff;
   logic signed [uhj_pkg::ProdBits-1:0] prod_ff;
   logic signed [uhj_pkg::AccBits-1:0] acc_ff, acc_in;
   uhj_pkg::hist_type in0_ff [uhj_pkg::SecCount];
   uhj_pkg::hist_type in1_ff [uhj_pkg::SecCount];
   uhj_pkg::hist_type out0_ff [uhj_pkg::SecCount];
   uhj_pkg::hist_type out1_ff [uhj_pkg::SecCount];
   logic signed [uhj_pkg::SumBits-1:0] sum_l_ff, sum_r_ff;
   logic signed [uhj_pkg::DeltaBits-1:0] dl_ff, dr_ff;
   logic signed [SAMPLE_BITS-1:0] left_ff, right_ff;
   logic end_ff;

   uhj_pkg::coef_type mul_a;
   logic signed [uhj_pkg::OperBits-1:0] mul_b;
   uhj_pkg::hist_type sec_in, x1, wr_val;
   logic signed [uhj_pkg::AccBits-uhj_pkg::FracShift-1:0] rnd;
   logic signed [uhj_pkg::DiffBits-1:0] diff;

   // Section input: chain head takes its term, later sections the previous output
   always_comb begin
      sec_in = v_ff;
      if (cmd.sec_idx[1:0] == 2'd0) begin
         unique case (cmd.sec_idx[3:2])
            2'd0: sec_in = term0_ff;
            2'd1: sec_in = term1_ff;
            default: sec_in = term2_ff;
         endcase
      end
   end

   always_comb begin
      if (cmd.mul_sel == uhj_pkg::MS_SEC) begin
         mul_a = uhj_pkg::sec_coef(cmd.sec_idx);
      end else begin
         mul_a = uhj_pkg::pre_coef(cmd.mul_sel);
      end
      unique case (cmd.mul_sel)
         uhj_pkg::MS_Y:    mul_b = uhj_pkg::OperBits'(y_q_ff);
         uhj_pkg::MS_WX_W,
         uhj_pkg::MS_S_W:  mul_b = uhj_pkg::OperBits'(w_q_ff);
         uhj_pkg::MS_WX_X,
         uhj_pkg::MS_S_X:  mul_b = uhj_pkg::OperBits'(x_q_ff);
         default: mul_b = uhj_pkg::OperBits'(sec_in)
                          + uhj_pkg::OperBits'(out1_ff[cmd.sec_idx]);
      endcase
   end

   assign acc_in = (cmd.acc_first ? '0 : acc_ff) + uhj_pkg::AccBits'(prod_ff)
                   + (cmd.acc_round ? uhj_pkg::RoundHalf : '0);

   // Round-shifted value, minus the older input for an allpass section, saturated
   always_comb begin
      x1   = cmd.sec_wr ? in1_ff[cmd.sec_idx] : '0;
      rnd  = acc_ff[uhj_pkg::AccBits-1:uhj_pkg::FracShift];
      diff = uhj_pkg::DiffBits'(rnd) - uhj_pkg::DiffBits'(x1);
      if (diff > uhj_pkg::HistMax) begin
         wr_val = uhj_pkg::HistMax[uhj_pkg::HistBits-1:0];
      end else if (diff < uhj_pkg::HistMin) begin
         wr_val = uhj_pkg::HistMin[uhj_pkg::HistBits-1:0];
      end else begin
         wr_val = diff[uhj_pkg::HistBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_q_ff  <= to_q29(w_sample);
         x_q_ff  <= to_q29(x_sample);
         y_q_ff  <= to_q29(y_sample);
         la_ff   <= left_accum;
         ra_ff   <= right_accum;
         last_ff <= last_in_block;
         ydel_ff <= out0_ff[uhj_pkg::YLastSec];
         sdel_ff <= out0_ff[uhj_pkg::SLastSec];
      end
      if (cmd.mul_en) begin
         prod_ff <= uhj_pkg::ProdBits'(mul_a) * uhj_pkg::ProdBits'(mul_b);
      end
      if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.term_wr) begin
         unique case (cmd.term_idx)
            2'd0: term0_ff <= wr_val;
            2'd1: term1_ff <= wr_val;
            default: term2_ff <= wr_val;
         endcase
      end
      if (cmd.sec_wr) begin
         v_ff <= wr_val;
         if (cmd.sec_idx == SecIdxWx) begin
            wx_ff <= wr_val;
         end
      end
      if (cmd.fin_sum) begin
         sum_l_ff <= uhj_pkg::SumBits'(sdel_ff) + uhj_pkg::SumBits'(ydel_ff)
                     + uhj_pkg::SumBits'(wx_ff);
         sum_r_ff <= uhj_pkg::SumBits'(sdel_ff) - uhj_pkg::SumBits'(ydel_ff)
                     - uhj_pkg::SumBits'(wx_ff);
      end
      if (cmd.fin_delta) begin
         dl_ff <= to_delta(sum_l_ff);
         dr_ff <= to_delta(sum_r_ff);
      end
      if (cmd.fin_out) begin
         left_ff  <= mix_sat(la_ff, dl_ff);
         right_ff <= mix_sat(ra_ff, dr_ff);
         end_ff   <= last_ff;
      end
   end

   // Allpass histories, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < uhj_pkg::SecCount; i++) begin
            in0_ff[i]  <= '0;
            in1_ff[i]  <= '0;
            out0_ff[i] <= '0;
            out1_ff[i] <= '0;
         end
      end else if (cmd.sec_wr) begin
         in1_ff[cmd.sec_idx]  <= in0_ff[cmd.sec_idx];
         in0_ff[cmd.sec_idx]  <= sec_in;
         out1_ff[cmd.sec_idx] <= out0_ff[cmd.sec_idx];
         out0_ff[cmd.sec_idx] <= wr_val;
      end
   end

   assign left_out     = left_ff;
   assign right_out    = right_ff;
   assign end_of_block = end_ff;

endmodule

// ----- rtl/core/uhj_ctrl.sv -----
// Controller: sequences multiply, accumulate and write steps over the twelve sections.
module uhj_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output uhj_pkg::cmd_type cmd
);

   uhj_pkg::state_type state_ff, state_in;
   logic [uhj_pkg::OpBits-1:0] op_ff, op_in, op_sec;
   logic rsp_valid_ff, rsp_valid_in;
   logic is_sec, is_last_op, pre_first, pre_last;
   uhj_pkg::mul_sel_type pre_sel;
   logic [1:0] pre_term;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uhj_pkg::ST_IDLE;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign is_sec     = op_ff >= uhj_pkg::OpBits'(uhj_pkg::FirstSecOp);
   assign is_last_op = op_ff == uhj_pkg::OpBits'(uhj_pkg::LastOp);
   assign op_sec     = op_ff - uhj_pkg::OpBits'(uhj_pkg::FirstSecOp);

   // Input matrix terms: Y alone, then W and X pairs for WX and S
   always_comb begin
      unique case (op_ff)
         5'd0: begin
            pre_sel = uhj_pkg::MS_Y;    pre_first = 1'b1; pre_last = 1'b1; pre_term = 2'd0;
         end
         5'd1: begin
            pre_sel = uhj_pkg::MS_WX_W; pre_first = 1'b1; pre_last = 1'b0; pre_term = 2'd1;
         end
         5'd2: begin
            pre_sel = uhj_pkg::MS_WX_X; pre_first = 1'b0; pre_last = 1'b1; pre_term = 2'd1;
         end
         5'd3: begin
            pre_sel = uhj_pkg::MS_S_W;  pre_first = 1'b1; pre_last = 1'b0; pre_term = 2'd2;
         end
         5'd4: begin
            pre_sel = uhj_pkg::MS_S_X;  pre_first = 1'b0; pre_last = 1'b1; pre_term = 2'd2;
         end
         default: begin
            pre_sel = uhj_pkg::MS_SEC;  pre_first = 1'b1; pre_last = 1'b1; pre_term = 2'd0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.mul_sel  = is_sec ? uhj_pkg::MS_SEC : pre_sel;
      cmd.sec_idx  = is_sec ? op_sec[uhj_pkg::SecBits-1:0] : '0;
      cmd.term_idx = pre_term;
      req_tready   = 1'b0;
      unique case (state_ff)
         uhj_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               op_in    = '0;
               state_in = uhj_pkg::ST_MUL;
            end
         end
         uhj_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = uhj_pkg::ST_ACC;
         end
         uhj_pkg::ST_ACC: begin
            cmd.acc_en    = 1'b1;
            cmd.acc_first = is_sec || pre_first;
            cmd.acc_round = is_sec || pre_last;
            if (is_sec || pre_last) begin
               state_in = uhj_pkg::ST_WR;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = uhj_pkg::ST_MUL;
            end
         end
         uhj_pkg::ST_WR: begin
            cmd.term_wr = !is_sec;
            cmd.sec_wr  = is_sec;
            if (is_last_op) begin
               state_in = uhj_pkg::ST_FIN_SUM;
            end else begin
               op_in    = op_ff + 1'b1;
               state_in = uhj_pkg::ST_MUL;
            end
         end
         uhj_pkg::ST_FIN_SUM: begin
            cmd.fin_sum = 1'b1;
            state_in    = uhj_pkg::ST_FIN_DELTA;
         end
         uhj_pkg::ST_FIN_DELTA: begin
            cmd.fin_delta = 1'b1;
            state_in      = uhj_pkg::ST_FIN_OUT;
         end
         uhj_pkg::ST_FIN_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.fin_out  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = uhj_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = uhj_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_start_seq: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> state_ff == uhj_pkg::ST_MUL && op_ff == '0)
      else $error("sequence did not restart at first step");

   a_op_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != uhj_pkg::ST_IDLE |-> op_ff <= uhj_pkg::OpBits'(uhj_pkg::LastOp))
      else $error("step counter out of range");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == uhj_pkg::ST_FIN_OUT)
      else $error("response raised outside output step");

   a_sec_idx: assert property (@(posedge clock) disable iff (reset)
      cmd.sec_wr |-> cmd.sec_idx < uhj_pkg::SecBits'(uhj_pkg::SecCount) && !cmd.term_wr)
      else $error("section write with bad index");

endmodule

// ----- rtl/core/uhj_two_channel_encoder_top.sv -----
// Top level of the two-channel UHJ encoder: stream ports, controller and datapath.
// A new request is taken only in the idle state, once the previous one has left its output step.
// Steps: one shared multiplier, a multiply step and an accumulate step per product, and one
// write per term or section (5 products, 3 terms, 12 sections), then three output steps.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous, active high) clears all allpass histories and the handshake state.
module uhj_two_channel_encoder_top #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // w_sample, x_sample, y_sample, left_accum, right_accum, zero pad
   input  logic [((5 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // left_out, right_out, zero pad
   output logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                                   rsp_tlast
);

   localparam int OutWidth = ((2 * SAMPLE_BITS + 7) / 8) * 8;

   uhj_pkg::cmd_type cmd;
   logic signed [SAMPLE_BITS-1:0] left_out, right_out;

   uhj_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   uhj_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .w_sample      (req_tdata[SAMPLE_BITS-1:0]),
      .x_sample      (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .y_sample      (req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
      .left_accum    (req_tdata[4*SAMPLE_BITS-1:3*SAMPLE_BITS]),
      .right_accum   (req_tdata[5*SAMPLE_BITS-1:4*SAMPLE_BITS]),
      .last_in_block (req_tlast),
      .left_out      (left_out),
      .right_out     (right_out),
      .end_of_block  (rsp_tlast)
   );

   assign rsp_tdata = OutWidth'({right_out, left_out});

endmodule
